// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker module of the spectrum bar block.
// Depends on nothing; a file that asserts includes it by its bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the active-low reset is held.
`define SBPH_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked while reset is held.
`define SBPH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/sbph_pkg.sv
// Package for the spectrum bar and peak-hold block: types, register codes and
// fixed-point constants. Used by the step divider, the top level and the checker.
package sbph_pkg;

  localparam int DEF_MAX_COLUMNS = 4096;
  localparam int DEF_BIN_COUNT   = 512;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAR_FALLOFF  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_FALLOFF = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_HOLD_ON = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_SCALE   = 3'd4;

  localparam logic [12:0] RST_SCREEN_WIDTH = 13'd640;
  localparam logic [5:0]  RST_BAR_FALLOFF  = 6'd8;
  localparam logic [5:0]  RST_PEAK_FALLOFF = 6'd8;
  localparam logic        RST_PEAK_HOLD_ON = 1'b1;
  localparam logic        RST_HALF_SCALE   = 1'b0;

  // Bin position in 9.16 fixed point; the span is 400 bins.
  localparam int FRAC_BITS = 16;
  localparam int POS_W     = 25;
  localparam int IPOS_W    = POS_W - FRAC_BITS;
  localparam int WIDTH_W   = 13;
  localparam logic [POS_W-1:0] STEP_NUM = POS_W'(400 * 65536);
  localparam logic [16:0] FRAC_ONE = 17'h10000;

  // Level scaling by (bin + 40) / 80, done as (x >> 4) / 5 by reciprocal.
  localparam logic [IPOS_W-1:0] LVL_OFFSET = IPOS_W'(40);
  localparam logic [15:0] RECIP_5     = 16'hCCCD;
  localparam int          RECIP_SHIFT = 18;

  localparam logic [6:0] CLAMP_FULL = 7'd127;
  localparam logic [6:0] CLAMP_HALF = 7'd63;
  localparam logic [8:0] SPD_MAX    = 9'd255;
  localparam int         SPD_SHIFT  = 5;

  typedef struct packed {
    logic [6:0] bar;
    logic [7:0] spd;
    logic [7:0] pk;
  } colst_t;

endpackage

// File: rtl/core/sbph_step_div.sv
// Iterative restoring divider that forms the bin step floor(400*65536/width).
// Depends on sbph_pkg for the widths and the fixed dividend.
module sbph_step_div
  import sbph_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [WIDTH_W-1:0] divisor,
  output logic               busy,
  output logic [POS_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(POS_W);

  logic [WIDTH_W-1:0] rem_r;
  logic [WIDTH_W-1:0] den_r;
  logic [POS_W-1:0]   quo_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;

  logic [WIDTH_W:0]   trial;
  logic               ge;
  logic [WIDTH_W:0]   rem_nxt;

  // One quotient bit per cycle: the dividend bits shift out of quo_r at the
  // top while the quotient bits shift in at the bottom.
  always_comb begin
    trial   = {rem_r, quo_r[POS_W-1]};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? (trial - {1'b0, den_r}) : trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(POS_W - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= divisor;
      quo_r <= STEP_NUM;
    end else if (busy_r) begin
      rem_r <= rem_nxt[WIDTH_W-1:0];
      quo_r <= {quo_r[POS_W-2:0], ge};
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

// File: rtl/core/spectrum_bar_peak_hold_top.sv
// Spectrum bar and peak-hold column engine: one transaction per clock cycle while busy
// is low, bin writes and column requests alike; a column result passes the stage registers
// s1 to s5 and the output register before it strobes, and the receiver cannot stall it.
// After reset busy stays high while the bin and column memories are cleared. A
// screen_width write holds busy while the step divider runs, one quotient bit per cycle.
module spectrum_bar_peak_hold_top
  import sbph_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int BIN_COUNT   = DEF_BIN_COUNT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_start,
  output logic                  busy,
  input  logic                  in_kind,
  input  logic [8:0]            in_bin_index,
  input  logic [7:0]            in_bin_value,
  input  logic [11:0]           in_column,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  out_strobe,
  output logic [11:0]           out_column_out,
  output logic [6:0]            out_bar_height,
  output logic [6:0]            out_peak_height,
  output logic                  out_peak_visible
);

  localparam int COL_AW = $clog2(MAX_COLUMNS);
  localparam int BIN_AW = $clog2(BIN_COUNT);
  localparam int CLR_N  = (MAX_COLUMNS > BIN_COUNT) ? MAX_COLUMNS : BIN_COUNT;
  localparam int CLR_W  = $clog2(CLR_N);

  // Configuration registers.
  logic [WIDTH_W-1:0] width_r;
  logic [5:0]         bar_fall_r;
  logic [5:0]         peak_fall_r;
  logic               hold_r;
  logic               half_r;
  logic               div_go_r;

  logic               cfg_fire;
  logic               div_busy;
  logic [POS_W-1:0]   step_q;

  // Reset clearing pass.
  logic               clr_r;
  logic [CLR_W-1:0]   clr_cnt_r;

  // Memories.
  logic [7:0]         spec_mem [BIN_COUNT];
  colst_t             col_mem  [MAX_COLUMNS];

  // Pipeline.
  logic               accept;
  logic               col_ok;
  logic               bin_wr;
  logic [POS_W+11:0]  pos_full;

  logic               s1_vld_r;
  logic [11:0]        s1_col_r;
  logic [POS_W-1:0]   s1_pos_r;
  logic [IPOS_W-1:0]  ipos;
  logic [IPOS_W-1:0]  ipos1;

  logic               s2_vld_r;
  logic [11:0]        s2_col_r;
  logic [15:0]        s2_frac_r;
  logic [IPOS_W-1:0]  s2_ipos_r;
  logic [7:0]         b0_r;
  logic [7:0]         b1_r;
  logic [24:0]        interp;

  logic               s3_vld_r;
  logic [11:0]        s3_col_r;
  logic [7:0]         s3_lvl_r;
  logic [IPOS_W-1:0]  s3_scale_r;

  logic               s4_vld_r;
  logic [11:0]        s4_col_r;
  logic [16:0]        s4_prod_r;
  logic [28:0]        quot_full;
  logic [10:0]        quot;
  logic [10:0]        lvl_sh;
  logic [6:0]         lvl_lim;
  logic [6:0]         lvl_clamped;

  logic               s5_vld_r;
  logic [11:0]        s5_col_r;
  logic [6:0]         s5_lvl_r;
  colst_t             col_rd_r;

  logic               wr_vld_r;
  logic [11:0]        wr_col_r;
  colst_t             wr_data_r;

  colst_t             cur;
  colst_t             upd;
  logic               vis;

  logic               out_strobe_r;
  logic [11:0]        out_col_r;
  logic [6:0]         out_bar_r;
  logic [6:0]         out_pk_r;
  logic               out_vis_r;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign busy      = clr_r || div_busy || div_go_r;
  assign accept    = in_start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= RST_SCREEN_WIDTH;
      bar_fall_r  <= RST_BAR_FALLOFF;
      peak_fall_r <= RST_PEAK_FALLOFF;
      hold_r      <= RST_PEAK_HOLD_ON;
      half_r      <= RST_HALF_SCALE;
      div_go_r    <= 1'b1;
    end else begin
      div_go_r <= 1'b0;
      if (cfg_fire) begin
        unique case (cfg_index)
          REG_SCREEN_WIDTH: begin
            width_r  <= cfg_wdata[WIDTH_W-1:0];
            div_go_r <= 1'b1;
          end
          REG_BAR_FALLOFF:  bar_fall_r  <= cfg_wdata[5:0];
          REG_PEAK_FALLOFF: peak_fall_r <= cfg_wdata[5:0];
          REG_PEAK_HOLD_ON: hold_r      <= cfg_wdata[0];
          REG_HALF_SCALE:   half_r      <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  sbph_step_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go_r),
    .divisor  (width_r),
    .busy     (div_busy),
    .quotient (step_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == CLR_W'(CLR_N - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  // Stage 1: range check and bin position.
  assign col_ok   = (width_r != '0) && ({1'b0, in_column} < width_r) &&
                    (int'(in_column) < MAX_COLUMNS);
  assign bin_wr   = accept && !in_kind && (int'(in_bin_index) < BIN_COUNT);
  assign pos_full = (POS_W+12)'(in_column) * (POS_W+12)'(step_q);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept && in_kind && col_ok;
    end
  end

  always_ff @(posedge clk) begin
    s1_col_r <= in_column;
    s1_pos_r <= pos_full[POS_W-1:0];
  end

  // Spectrum store: one write port, two registered read ports.
  assign ipos  = s1_pos_r[POS_W-1:FRAC_BITS];
  assign ipos1 = ipos + IPOS_W'(1);

  always_ff @(posedge clk) begin
    if (clr_r) begin
      if (int'(clr_cnt_r) < BIN_COUNT) begin
        spec_mem[BIN_AW'(clr_cnt_r)] <= '0;
      end
    end else if (bin_wr) begin
      spec_mem[BIN_AW'(in_bin_index)] <= in_bin_value;
    end
    b0_r <= spec_mem[BIN_AW'(ipos)];
    b1_r <= spec_mem[BIN_AW'(ipos1)];
  end

  // Stage 2: the bins arrive; hold the fraction and integer position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_col_r  <= s1_col_r;
    s2_frac_r <= s1_pos_r[FRAC_BITS-1:0];
    s2_ipos_r <= ipos;
  end

  // Stage 3: linear interpolation between the two bins.
  assign interp = (25'(b1_r) * 25'(s2_frac_r)) +
                  (25'(b0_r) * 25'(FRAC_ONE - {1'b0, s2_frac_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_col_r   <= s2_col_r;
    s3_lvl_r   <= interp[23:16];
    s3_scale_r <= s2_ipos_r + LVL_OFFSET;
  end

  // Stage 4: multiply by (bin + 40).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_col_r  <= s3_col_r;
    s4_prod_r <= 17'(s3_lvl_r) * 17'(s3_scale_r);
  end

  // Stage 5: divide by 80 as a shift by four and a reciprocal multiply by one
  // fifth, which is exact for these magnitudes; then halve in half-scale mode and clamp.
  always_comb begin
    quot_full   = 29'(s4_prod_r[16:4]) * 29'(RECIP_5);
    quot        = quot_full[28:RECIP_SHIFT];
    lvl_sh      = half_r ? (quot >> 1) : quot;
    lvl_lim     = half_r ? CLAMP_HALF : CLAMP_FULL;
    lvl_clamped = (lvl_sh > 11'(lvl_lim)) ? lvl_lim : lvl_sh[6:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s5_col_r <= s4_col_r;
    s5_lvl_r <= lvl_clamped;
  end

  // Column state: read in stage 5, modified and written back in stage 6. The
  // write of the transaction just ahead lands on the same edge as this read, so
  // that one write is kept aside and forwarded.
  always_ff @(posedge clk) begin
    if (clr_r) begin
      if (int'(clr_cnt_r) < MAX_COLUMNS) begin
        col_mem[COL_AW'(clr_cnt_r)] <= '0;
      end
    end else if (s5_vld_r) begin
      col_mem[COL_AW'(s5_col_r)] <= upd;
    end
    col_rd_r <= col_mem[COL_AW'(s4_col_r)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_vld_r <= 1'b0;
    end else begin
      wr_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    wr_col_r  <= s5_col_r;
    wr_data_r <= upd;
  end

  // Stage 6: peak decay and peak capture when peak hold is on, and bar falloff.
  always_comb begin
    logic [8:0] spd_sum;
    logic [7:0] spd_inc;
    logic [2:0] dec;
    logic [7:0] pk_dec;
    logic [7:0] lvl2;
    logic [6:0] bf2;
    logic [6:0] bar_new;

    cur     = (wr_vld_r && (wr_col_r == s5_col_r)) ? wr_data_r : col_rd_r;
    spd_sum = {1'b0, cur.spd} + {3'b0, peak_fall_r};
    spd_inc = (spd_sum < SPD_MAX) ? spd_sum[7:0] : SPD_MAX[7:0];
    dec     = spd_inc[7:SPD_SHIFT];
    pk_dec  = (cur.pk < {5'b0, dec}) ? 8'd0 : (cur.pk - {5'b0, dec});
    lvl2    = {s5_lvl_r, 1'b0};
    bf2     = {bar_fall_r, 1'b0};

    upd = cur;
    vis = 1'b0;
    if (hold_r) begin
      if (lvl2 > pk_dec) begin
        upd.spd = '0;
        upd.pk  = lvl2;
      end else begin
        upd.spd = spd_inc;
        upd.pk  = pk_dec;
      end
      vis = (upd.pk[7:1] >= s5_lvl_r) && (upd.pk[7:1] != '0);
    end

    bar_new = s5_lvl_r;
    if ((cur.bar > bf2) && (s5_lvl_r < (cur.bar - bf2))) begin
      bar_new = cur.bar - bf2;
    end
    upd.bar = bar_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s5_vld_r) begin
      out_col_r <= s5_col_r;
      out_bar_r <= upd.bar;
      out_pk_r  <= upd.pk[7:1];
      out_vis_r <= vis;
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_column_out   = out_col_r;
  assign out_bar_height   = out_bar_r;
  assign out_peak_height  = out_pk_r;
  assign out_peak_visible = out_vis_r;

endmodule

// File: rtl/core/sbph_checker.sv
// Port-level checker for the spectrum bar block, bound to the top level.
// Depends on sbph_pkg and on assert_macros.svh.
`include "assert_macros.svh"

module sbph_checker
  import sbph_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_start,
  input logic                  busy,
  input logic                  in_kind,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic                  out_strobe,
  input logic [6:0]            out_peak_height,
  input logic                  out_peak_visible
);

  // Every result traces back to an accepted column transaction.
  `SBPH_ASSERT(a_result_has_column, clk, rst_n, out_strobe |-> $past(in_start && !busy && in_kind, 6), "result without an accepted column transaction")

  // A visible peak marker always has some height.
  `SBPH_ASSERT(a_visible_peak_nonzero, clk, rst_n, (out_strobe && out_peak_visible) |-> (out_peak_height != '0), "visible peak of zero height")

  // The clearing pass keeps the block busy when reset is released.
  `SBPH_ASSERT(a_busy_after_reset, clk, rst_n, $rose(rst_n) |-> busy, "not busy after reset release")

  // A new screen width holds off transactions while the step is recomputed.
  `SBPH_ASSERT(a_busy_after_width, clk, rst_n, (cfg_valid && cfg_ready && (cfg_index == REG_SCREEN_WIDTH)) |=> busy, "not busy after a screen width write")

  // No result is strobed during reset or on the edge that follows it.
  `SBPH_ASSERT_ALWAYS(a_no_result_in_reset, clk, !rst_n |=> !out_strobe, "result strobed during reset")

endmodule

bind spectrum_bar_peak_hold_top sbph_checker u_sbph_checker (.*);
